// ----- rtl/rbde_pkg.sv -----
package rbde_pkg;

    // function codes of an input item
    localparam logic [1:0] FUNC_START_DISC  = 2'd0;
    localparam logic [1:0] FUNC_START_IDENT = 2'd1;
    localparam logic [1:0] FUNC_RX_DISC     = 2'd2;
    localparam logic [1:0] FUNC_RX_ENUM     = 2'd3;

    // frame kinds sent onto the ring
    localparam logic [1:0] KIND_DISCOVER = 2'd0;
    localparam logic [1:0] KIND_ENUM     = 2'd1;
    localparam logic [1:0] KIND_IDENT    = 2'd2;

    // sequence ceiling for forwarding, and nibble of a node without an id
    localparam logic [3:0] SEQ_LIMIT    = 4'hf;
    localparam logic [3:0] NO_ID_NIBBLE = 4'hf;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UUID_LOW        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UUID_HIGH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION_BYTE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT_BYTE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARAMS_PER_NODE = 3'd4;

    // index of the last frame in one ident burst
    localparam logic [2:0] IDENT_LAST_IDX = 3'd5;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] node_nibble;
        logic [7:0] data_byte_1;
        logic [7:0] data_byte_2;
        logic [7:0] data_byte_3;
    } in_item_t;

    typedef struct packed {
        logic [1:0] frame_kind;
        logic [3:0] frame_nibble;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic       last_frame;
    } out_item_t;

    typedef struct packed {
        logic [63:0] uuid_low;
        logic [63:0] uuid_high;
        logic [7:0]  version_byte;
        logic [7:0]  product_byte;
        logic [7:0]  params_per_node;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] nibble;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } frame_t;

    typedef enum logic [1:0] {
        JOB_ONE,
        JOB_TWO,
        JOB_IDENT
    } job_op_t;

    // one queued job: up to two ready-made frames, or an ident burst
    typedef struct packed {
        job_op_t op;
        frame_t  f0;
        frame_t  f1;
    } job_t;

    function automatic logic [7:0] id_byte(input cfg_t c, input logic [3:0] i);
        logic [127:0] w;
        w = {c.uuid_high, c.uuid_low};
        return w[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [23:0] make_token(input cfg_t c);
        logic [7:0] t_hi;
        logic [7:0] t_mid;
        logic [7:0] t_lo;
        t_hi  = c.version_byte ^ id_byte(c, 4'd10) ^ id_byte(c, 4'd7)
              ^ id_byte(c, 4'd4) ^ id_byte(c, 4'd1);
        t_mid = id_byte(c, 4'd9) ^ id_byte(c, 4'd6) ^ id_byte(c, 4'd3)
              ^ id_byte(c, 4'd0);
        t_lo  = id_byte(c, 4'd11) ^ id_byte(c, 4'd8) ^ id_byte(c, 4'd5)
              ^ id_byte(c, 4'd2) ^ c.product_byte;
        return {t_hi, t_mid, t_lo};
    endfunction

endpackage

// ----- rtl/rbde_front.sv -----
module rbde_front (
    input  logic              clk,
    input  logic              rst_n,
    input  rbde_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  rbde_pkg::in_item_t in_data,
    output logic              in_stall,
    input  logic              q_full,
    output logic              push,
    output rbde_pkg::job_t    push_job
);
    import rbde_pkg::*;

    logic        token_ready_reg, token_ready_next;
    logic [23:0] token_reg, token_next;
    logic [3:0]  node_id_reg, node_id_next;
    logic        node_id_valid_reg, node_id_valid_next;
    logic [3:0]  peer_count_reg, peer_count_next;

    logic        accept;
    logic        want_push;
    logic [23:0] tok;
    logic [23:0] other;
    logic        seq_ok;
    logic        no_peers;
    frame_t      own_frame;
    frame_t      fwd_frame;
    frame_t      enum_frame;
    logic [3:0]  enum_id;
    logic [7:0]  enum_offset;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && want_push;

    always_comb
    begin
        tok      = token_ready_reg ? token_reg : make_token(cfg);
        other    = {in_data.data_byte_1, in_data.data_byte_2, in_data.data_byte_3};
        seq_ok   = (in_data.node_nibble < SEQ_LIMIT);
        no_peers = (peer_count_reg == 4'd0);

        own_frame = '{kind: KIND_DISCOVER, nibble: 4'd0,
                      b1: tok[23:16], b2: tok[15:8], b3: tok[7:0]};
        fwd_frame = '{kind: KIND_DISCOVER, nibble: in_data.node_nibble + 4'd1,
                      b1: other[23:16], b2: other[15:8], b3: other[7:0]};

        // enum from id 0 on token return carries offset params_per_node, otherwise id sender+1, offset sender's+params
        enum_id     = (in_data.func == FUNC_RX_ENUM) ? in_data.node_nibble + 4'd1 : 4'd0;
        enum_offset = ((in_data.func == FUNC_RX_ENUM) ? in_data.data_byte_3 : 8'd0)
                    + cfg.params_per_node;
        enum_frame  = '{kind: KIND_ENUM, nibble: enum_id,
                        b1: cfg.version_byte, b2: cfg.product_byte, b3: enum_offset};

        token_ready_next   = token_ready_reg;
        token_next         = token_reg;
        node_id_next       = node_id_reg;
        node_id_valid_next = node_id_valid_reg;
        peer_count_next    = peer_count_reg;
        want_push          = 1'b0;
        push_job           = '{op: JOB_ONE, f0: own_frame, f1: fwd_frame};

        unique case (in_data.func)
            FUNC_START_DISC:
            begin
                token_ready_next = 1'b1;
                token_next       = tok;
                if (no_peers)
                begin
                    node_id_next       = 4'd0;
                    node_id_valid_next = 1'b1;
                    want_push          = 1'b1;
                end
            end
            FUNC_START_IDENT:
            begin
                want_push          = 1'b1;
                push_job.op        = JOB_IDENT;
                push_job.f0.kind   = KIND_IDENT;
                push_job.f0.nibble = node_id_valid_reg ? node_id_reg : NO_ID_NIBBLE;
            end
            FUNC_RX_DISC:
            begin
                if (!token_ready_reg)
                begin
                    token_ready_next = 1'b1;
                    token_next       = tok;
                    if (no_peers)
                    begin
                        node_id_next       = 4'd0;
                        node_id_valid_next = 1'b1;
                        want_push          = 1'b1;
                        push_job.op        = seq_ok ? JOB_TWO : JOB_ONE;
                    end
                    else if (seq_ok)
                    begin
                        want_push   = 1'b1;
                        push_job.f0 = fwd_frame;
                    end
                end
                else if (other == token_reg)
                begin
                    // own token came home: its sequence is the peer count
                    peer_count_next = in_data.node_nibble;
                    if (node_id_valid_reg && node_id_reg == 4'd0)
                    begin
                        want_push   = 1'b1;
                        push_job.f0 = enum_frame;
                    end
                end
                else
                begin
                    if (other > token_reg)
                        node_id_valid_next = 1'b0;
                    if (seq_ok)
                    begin
                        want_push   = 1'b1;
                        push_job.f0 = fwd_frame;
                    end
                end
            end
            FUNC_RX_ENUM:
            begin
                if (!node_id_valid_reg)
                begin
                    node_id_next       = enum_id;
                    node_id_valid_next = 1'b1;
                    want_push          = 1'b1;
                    push_job.f0        = enum_frame;
                end
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_ready_reg   <= 1'b0;
            token_reg         <= '0;
            node_id_reg       <= '0;
            node_id_valid_reg <= 1'b0;
            peer_count_reg    <= '0;
        end
        else if (accept)
        begin
            token_ready_reg   <= token_ready_next;
            token_reg         <= token_next;
            node_id_reg       <= node_id_next;
            node_id_valid_reg <= node_id_valid_next;
            peer_count_reg    <= peer_count_next;
        end
    end

endmodule

// ----- rtl/rbde_queue.sv -----
module rbde_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rbde_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rbde_pkg::job_t head_job
);
    import rbde_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/rbde_back.sv -----
module rbde_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rbde_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  rbde_pkg::job_t     head_job,
    output logic               pop,
    output logic               out_valid,
    output rbde_pkg::out_item_t out_data,
    input  logic               out_stall
);
    import rbde_pkg::*;

    logic      cur_valid_reg, cur_valid_next;
    job_t      cur_job_reg;
    logic [2:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    logic      advance;
    logic      is_last;
    frame_t    frame;

    assign advance   = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign pop       = head_valid && (!cur_valid_reg || (advance && is_last));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        frame = cur_job_reg.f0;
        unique case (cur_job_reg.op)
            JOB_ONE:
            begin
                is_last = 1'b1;
            end
            JOB_TWO:
            begin
                is_last = (idx_reg == 3'd1);
                if (idx_reg != 3'd0)
                    frame = cur_job_reg.f1;
            end
            JOB_IDENT:
            begin
                is_last = (idx_reg == IDENT_LAST_IDX);
                // version and product lead the first frame; id bytes follow highest first, three to each later frame
                unique case (idx_reg)
                    3'd0:
                    begin
                        frame.b1 = cfg.version_byte;
                        frame.b2 = cfg.product_byte;
                        frame.b3 = id_byte(cfg, 4'd15);
                    end
                    3'd1:
                    begin
                        frame.b1 = id_byte(cfg, 4'd14);
                        frame.b2 = id_byte(cfg, 4'd13);
                        frame.b3 = id_byte(cfg, 4'd12);
                    end
                    3'd2:
                    begin
                        frame.b1 = id_byte(cfg, 4'd11);
                        frame.b2 = id_byte(cfg, 4'd10);
                        frame.b3 = id_byte(cfg, 4'd9);
                    end
                    3'd3:
                    begin
                        frame.b1 = id_byte(cfg, 4'd8);
                        frame.b2 = id_byte(cfg, 4'd7);
                        frame.b3 = id_byte(cfg, 4'd6);
                    end
                    3'd4:
                    begin
                        frame.b1 = id_byte(cfg, 4'd5);
                        frame.b2 = id_byte(cfg, 4'd4);
                        frame.b3 = id_byte(cfg, 4'd3);
                    end
                    default:
                    begin
                        frame.b1 = id_byte(cfg, 4'd2);
                        frame.b2 = id_byte(cfg, 4'd1);
                        frame.b3 = id_byte(cfg, 4'd0);
                    end
                endcase
            end
            default:
            begin
                is_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (advance)
        begin
            if (is_last)
                cur_valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end

        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_job_reg <= head_job;
        if (advance)
            out_reg <= '{frame_kind: frame.kind, frame_nibble: frame.nibble,
                         out_byte_1: frame.b1, out_byte_2: frame.b2,
                         out_byte_3: frame.b3, last_frame: is_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ring_bus_discover_enumerate.sv -----
// channel | direction | handshake          | payload
// in      | to node   | in_valid/in_stall   | in_data (func, nibble, three data bytes)
// out     | from node | out_valid/out_stall | out_data (one frame to send onto the ring)
// cfg     | to node   | cfg_we              | cfg_index, cfg_data
//
// the front takes one beat per cycle while the job queue (two entries) has room
// the back sends one frame per cycle while out is not stalled: an ident start yields six frames,
// a discover received before any token up to two, everything else one or none
// an accepted beat goes through a queue slot, the current job register and the output register to its first frame
// reset clears node state, the queue count and out_valid; config resets to zero
// a stall on out backs up the queue and then raises in_stall
module ring_bus_discover_enumerate (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  rbde_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output rbde_pkg::out_item_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [rbde_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [63:0]                            cfg_data
);
    import rbde_pkg::*;

    cfg_t cfg_reg;

    // front to queue
    logic q_full;
    logic push;
    job_t push_job;

    // queue to back
    logic head_valid;
    job_t head_job;
    logic pop;

    // configuration registers; the user must write them only while the node is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UUID_LOW:        cfg_reg.uuid_low        <= cfg_data;
                CFG_UUID_HIGH:       cfg_reg.uuid_high       <= cfg_data;
                CFG_VERSION_BYTE:    cfg_reg.version_byte    <= cfg_data[7:0];
                CFG_PRODUCT_BYTE:    cfg_reg.product_byte    <= cfg_data[7:0];
                CFG_PARAMS_PER_NODE: cfg_reg.params_per_node <= cfg_data[7:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // front: holds token, id and peer count, turns each beat into at most one job
    rbde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // short job queue so the front keeps taking beats while frames drain
    rbde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: expands jobs into frames behind a registered output
    rbde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_stall  (out_stall)
    );

endmodule

// ----- rtl/rbde_checker.sv -----
module rbde_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input rbde_pkg::out_item_t out_data
);
    import rbde_pkg::*;

    // a stalled frame stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped under stall");

    // and does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out payload changed under stall");

    // no fourth frame kind is ever sent
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.frame_kind <= KIND_IDENT)
        else $error("bad frame kind");

    // an enum frame always ends its job
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_kind == KIND_ENUM |-> out_data.last_frame)
        else $error("enum frame not last");

    // a sent ident frame that is not last is followed by another ident frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.frame_kind == KIND_IDENT
            && !out_data.last_frame
        |=> out_valid && out_data.frame_kind == KIND_IDENT)
        else $error("ident burst broken");

endmodule

bind ring_bus_discover_enumerate rbde_checker u_rbde_checker (.*);
